### hw/rtl/tbeq_pkg.sv
// ----------------------------------------------------------------------------
// tbeq_pkg
// Shared types and fixed constants of the three-band equaliser.
// ----------------------------------------------------------------------------
package tbeq_pkg;

	localparam int N_CH       = 2;
	localparam int N_STAGES   = 4;
	localparam int STAGE_W    = $clog2(N_STAGES);
	localparam int SLOT_W     = 1 + STAGE_W;
	localparam int N_SLOTS    = N_CH * N_STAGES;
	localparam int HIST_DEPTH = 3;

	localparam int CFG_IDX_W  = 3;
	localparam int COEF_REG_W = 17;
	localparam int GAIN_W     = 16;
	localparam int GAIN_FRAC  = 14;

	localparam logic [COEF_REG_W-1:0] LOW_COEF_RST  = 17'd7466;
	localparam logic [COEF_REG_W-1:0] HIGH_COEF_RST = 17'd45706;
	localparam logic [GAIN_W-1:0]     GAIN_RST      = 16'd16384;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LOW_COEF  = 3'd0,
		CFG_HIGH_COEF = 3'd1,
		CFG_LOW_GAIN  = 3'd2,
		CFG_MID_GAIN  = 3'd3,
		CFG_HIGH_GAIN = 3'd4
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_POLE,
		ST_PREP,
		ST_GAIN,
		ST_DRAIN,
		ST_FIN
	} eq_state_t;

	// travels with each multiply through the pipeline
	typedef struct packed {
		logic               gain;
		logic               ch;
		logic [STAGE_W-1:0] stage;
		logic               first;
		logic               last;
	} mul_tag_t;

endpackage

### hw/rtl/tbeq_in_if.sv
// ----------------------------------------------------------------------------
// tbeq_in_if
// Stereo input frame channel: valid/ready handshake with two samples.
// ----------------------------------------------------------------------------
interface tbeq_in_if #(parameter int SAMPLE_BITS = 24);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] left_in;
	logic signed [SAMPLE_BITS-1:0] right_in;

	modport source (output valid, output left_in, output right_in, input ready);
	modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

### hw/rtl/tbeq_out_if.sv
// ----------------------------------------------------------------------------
// tbeq_out_if
// Stereo result frame channel: valid/ready handshake with two samples.
// ----------------------------------------------------------------------------
interface tbeq_out_if #(parameter int SAMPLE_BITS = 24);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] left_out;
	logic signed [SAMPLE_BITS-1:0] right_out;

	modport source (output valid, output left_out, output right_out, input ready);
	modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

### hw/rtl/tbeq_ram.sv
// ----------------------------------------------------------------------------
// tbeq_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tbeq_ram #(
	parameter int WIDTH = 40,
	parameter int DEPTH = 8,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### hw/rtl/tbeq_mul.sv
// ----------------------------------------------------------------------------
// tbeq_mul
// Three-stage signed by unsigned multiplier built from two half-width
// partial products, with a tag carried alongside.
// ----------------------------------------------------------------------------
module tbeq_mul #(
	parameter int A_W = 41,
	parameter int B_W = 18,
	localparam int P_W = A_W + B_W + 1
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_v,
	input  tbeq_pkg::mul_tag_t       in_tag,
	input  logic signed [A_W-1:0]    a,
	input  logic [B_W-1:0]           b,
	output logic                     out_v,
	output tbeq_pkg::mul_tag_t       out_tag,
	output logic signed [P_W-1:0]    prod
);

	localparam int ALW = (A_W + 1) / 2;
	localparam int AHW = A_W - ALW;

	logic                     v_s1, v_s2;
	tbeq_pkg::mul_tag_t       tag_s1, tag_s2;
	logic [ALW+B_W-1:0]       lo_s1, lo_s2;
	logic signed [AHW-1:0]    ahi_s1;
	logic [B_W-1:0]           b_s1;
	logic signed [AHW+B_W:0]  hi_s2;
	logic signed [P_W-1:0]    hi_ext;
	logic [P_W-1:0]           lo_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			out_v <= 1'b0;
		end else begin
			v_s1  <= in_v;
			v_s2  <= v_s1;
			out_v <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		tag_s1  <= in_tag;
		lo_s1   <= a[ALW-1:0] * b;
		ahi_s1  <= a[A_W-1:ALW];
		b_s1    <= b;
		tag_s2  <= tag_s1;
		lo_s2   <= lo_s1;
		hi_s2   <= ahi_s1 * $signed({1'b0, b_s1});
		out_tag <= tag_s2;
		prod    <= (hi_ext <<< ALW) + $signed(lo_ext);
	end

	assign hi_ext = P_W'(hi_s2);
	assign lo_ext = P_W'(lo_s2);

endmodule

### hw/rtl/three_band_equalizer.sv
// ----------------------------------------------------------------------------
// three_band_equalizer
// Stereo three-band equaliser: two four-pole lowpass cascades per channel,
// band gains, saturated sum. Pole state sits in two small RAMs.
// ----------------------------------------------------------------------------
// Frames are handled one at a time: a new frame is taken only when idle, once the
// previous result has gone into the output register, where it may still wait.
// Processing time is set by the four dependent pole updates, each a RAM read
// plus the 3-stage multiplier.
// Reset: pole entries read as zero through per-entry valid bits, input history
// clears, registers return to their defaults. No clearing pass.
module three_band_equalizer #(
	parameter int SAMPLE_BITS     = 24,
	parameter int COEF_FRAC_BITS  = 16,
	parameter int POLE_EXTRA_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [tbeq_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tbeq_pkg::COEF_REG_W-1:0]    cfg_wdata,
	tbeq_in_if.sink                            audio,
	tbeq_out_if.source                         equalized
);

	localparam int PB   = SAMPLE_BITS + POLE_EXTRA_BITS;
	localparam int DW   = PB + 1;
	localparam int CW   = COEF_FRAC_BITS + 2;
	localparam int GW   = tbeq_pkg::GAIN_W;
	localparam int BW   = (CW > GW) ? CW : GW;
	localparam int PW   = DW + BW + 1;
	localparam int SW   = PW + 1;
	localparam int AW   = PW + 2;
	localparam int KW   = tbeq_pkg::STAGE_W;
	localparam int SLW  = tbeq_pkg::SLOT_W;
	localparam int NCH  = tbeq_pkg::N_CH;
	localparam int HD   = tbeq_pkg::HIST_DEPTH;
	localparam int CRW  = tbeq_pkg::COEF_REG_W;

	localparam logic [KW-1:0]          K_LAST = KW'(tbeq_pkg::N_STAGES - 1);
	localparam logic signed [SW-1:0]   PMAX   = {{(SW-PB+1){1'b0}}, {(PB-1){1'b1}}};
	localparam logic signed [SW-1:0]   PMIN   = ~PMAX;
	localparam logic signed [AW-1:0]   OMAX   =
		{{(AW-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [AW-1:0]   OMIN   = ~OMAX;

	function automatic logic signed [PB-1:0] sat_pole(input logic signed [SW-1:0] v);
		logic signed [PB-1:0] r;
		if (v > PMAX)
			r = PMAX[PB-1:0];
		else if (v < PMIN)
			r = PMIN[PB-1:0];
		else
			r = v[PB-1:0];
		return r;
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] sat_out(input logic signed [AW-1:0] v);
		logic signed [SAMPLE_BITS-1:0] r;
		if (v > OMAX)
			r = OMAX[SAMPLE_BITS-1:0];
		else if (v < OMIN)
			r = OMIN[SAMPLE_BITS-1:0];
		else
			r = v[SAMPLE_BITS-1:0];
		return r;
	endfunction

	// configuration
	logic [CRW-1:0]         low_coef_q, high_coef_q;
	logic [GW-1:0]          low_gain_q, mid_gain_q, high_gain_q;
	logic [CW+CRW-1:0]      lc_ext, hc_ext;
	logic [CW-1:0]          coef_l, coef_h;

	// control
	tbeq_pkg::eq_state_t    state_q, state_d;
	logic [1:0]             kick_q;
	logic [1:0]             g_q;
	logic                   accept, gain_issue, fin_load, pole_done;

	// pole pipeline
	logic                   rd_v;
	logic                   rd_ch;
	logic [KW-1:0]          rd_k;
	logic [SLW-1:0]         raddr, waddr;
	logic [tbeq_pkg::N_SLOTS-1:0] pvld_q;
	logic                   v_s1, pv_s1, ch_s1;
	logic [KW-1:0]          k_s1;
	logic                   v_s2, ch_s2;
	logic [KW-1:0]          k_s2;
	logic [PB-1:0]          rdl, rdh, rl_eff, rh_eff;
	logic signed [DW-1:0]   diffl, diffh, diffl_s2, diffh_s2;
	logic signed [PB-1:0]   xl_q [NCH];
	logic signed [PB-1:0]   xh_q [NCH];
	logic signed [PB-1:0]   pl_q [NCH];
	logic signed [PB-1:0]   ph_q [NCH];

	// multipliers
	logic                   mi_v;
	tbeq_pkg::mul_tag_t     mi_tag;
	logic signed [DW-1:0]   a_l, a_h;
	logic [BW-1:0]          b_l, b_h;
	logic                   mul_v_l, mul_v_h;
	tbeq_pkg::mul_tag_t     mul_tag_l, mul_tag_h;
	logic signed [PW-1:0]   prod_l, prod_h;

	// write-back and bands
	logic                   w_v, g_v;
	logic                   w_ch;
	logic [KW-1:0]          w_k;
	logic signed [SW-1:0]   suml, sumh;
	logic signed [PB-1:0]   newpl, newph;
	logic signed [SAMPLE_BITS-1:0] smp_q [NCH];
	logic signed [SAMPLE_BITS-1:0] hist_q [NCH][HD];
	logic signed [DW-1:0]   h_q [NCH];
	logic signed [DW-1:0]   m_q [NCH];
	logic signed [AW-1:0]   acc_q [NCH];
	logic signed [AW-1:0]   tl, th;
	logic                   gch, gfirst, glast;

	// output register
	logic                          out_v_q;
	logic signed [SAMPLE_BITS-1:0] left_q, right_q;

	// ---------------------------------------------------------------- config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_coef_q  <= tbeq_pkg::LOW_COEF_RST;
			high_coef_q <= tbeq_pkg::HIGH_COEF_RST;
			low_gain_q  <= tbeq_pkg::GAIN_RST;
			mid_gain_q  <= tbeq_pkg::GAIN_RST;
			high_gain_q <= tbeq_pkg::GAIN_RST;
		end else if (cfg_we) begin
			case (tbeq_pkg::cfg_idx_t'(cfg_index))
				tbeq_pkg::CFG_LOW_COEF:  low_coef_q  <= cfg_wdata;
				tbeq_pkg::CFG_HIGH_COEF: high_coef_q <= cfg_wdata;
				tbeq_pkg::CFG_LOW_GAIN:  low_gain_q  <= cfg_wdata[GW-1:0];
				tbeq_pkg::CFG_MID_GAIN:  mid_gain_q  <= cfg_wdata[GW-1:0];
				tbeq_pkg::CFG_HIGH_GAIN: high_gain_q <= cfg_wdata[GW-1:0];
				default: ;
			endcase
		end
	end

	assign lc_ext = {{CW{1'b0}}, low_coef_q};
	assign hc_ext = {{CW{1'b0}}, high_coef_q};
	assign coef_l = lc_ext[CW-1:0];
	assign coef_h = hc_ext[CW-1:0];

	// ---------------------------------------------------------------- FSM
	assign accept    = audio.valid && audio.ready;
	assign w_v       = mul_v_l && !mul_tag_l.gain;
	assign g_v       = mul_v_l && mul_tag_l.gain;
	assign w_ch      = mul_tag_l.ch;
	assign w_k       = mul_tag_l.stage;
	assign pole_done = w_v && (w_k == K_LAST) && w_ch;
	assign gch       = g_q[1];
	assign gfirst    = !g_q[0];
	assign glast     = (g_q == 2'b11);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tbeq_pkg::ST_IDLE;
			kick_q  <= 2'b00;
			g_q     <= 2'b00;
		end else begin
			state_q <= state_d;
			kick_q  <= accept ? 2'b01 : {kick_q[0], 1'b0};
			if (gain_issue)
				g_q <= g_q + 2'b01;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			tbeq_pkg::ST_IDLE:  if (audio.valid) state_d = tbeq_pkg::ST_POLE;
			tbeq_pkg::ST_POLE:  if (pole_done) state_d = tbeq_pkg::ST_PREP;
			tbeq_pkg::ST_PREP:  state_d = tbeq_pkg::ST_GAIN;
			tbeq_pkg::ST_GAIN:  if (glast) state_d = tbeq_pkg::ST_DRAIN;
			tbeq_pkg::ST_DRAIN: if (g_v && mul_tag_l.last) state_d = tbeq_pkg::ST_FIN;
			tbeq_pkg::ST_FIN:   if (fin_load) state_d = tbeq_pkg::ST_IDLE;
			default:            state_d = tbeq_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		audio.ready = 1'b0;
		gain_issue  = 1'b0;
		fin_load    = 1'b0;
		case (state_q)
			tbeq_pkg::ST_IDLE: audio.ready = 1'b1;
			tbeq_pkg::ST_GAIN: gain_issue  = 1'b1;
			tbeq_pkg::ST_FIN:  fin_load    = !out_v_q || equalized.ready;
			default: ;
		endcase
	end

	// ---------------------------------------------------------------- pole RAMs
	assign rd_v = kick_q[0] || kick_q[1] || (w_v && (w_k != K_LAST));

	always_comb begin
		if (kick_q[0]) begin
			rd_ch = 1'b0;
			rd_k  = '0;
		end else if (kick_q[1]) begin
			rd_ch = 1'b1;
			rd_k  = '0;
		end else begin
			rd_ch = w_ch;
			rd_k  = w_k + KW'(1);
		end
	end

	assign raddr = {rd_ch, rd_k};
	assign waddr = {w_ch, w_k};

	tbeq_ram #(.WIDTH(PB), .DEPTH(tbeq_pkg::N_SLOTS)) u_low_ram (
		.clk   (clk),
		.we    (w_v),
		.waddr (waddr),
		.wdata (newpl),
		.re    (rd_v),
		.raddr (raddr),
		.rdata (rdl)
	);

	tbeq_ram #(.WIDTH(PB), .DEPTH(tbeq_pkg::N_SLOTS)) u_high_ram (
		.clk   (clk),
		.we    (w_v),
		.waddr (waddr),
		.wdata (newph),
		.re    (rd_v),
		.raddr (raddr),
		.rdata (rdh)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pvld_q <= '0;
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
		end else begin
			if (w_v)
				pvld_q[waddr] <= 1'b1;
			v_s1 <= rd_v;
			v_s2 <= v_s1;
		end
	end

	assign rl_eff = pv_s1 ? rdl : '0;
	assign rh_eff = pv_s1 ? rdh : '0;
	assign diffl  = DW'(xl_q[ch_s1]) - DW'($signed(rl_eff));
	assign diffh  = DW'(xh_q[ch_s1]) - DW'($signed(rh_eff));

	always_ff @(posedge clk) begin
		if (rd_v) begin
			pv_s1 <= pvld_q[raddr];
			ch_s1 <= rd_ch;
			k_s1  <= rd_k;
		end
		if (v_s1) begin
			diffl_s2    <= diffl;
			diffh_s2    <= diffh;
			ch_s2       <= ch_s1;
			k_s2        <= k_s1;
			pl_q[ch_s1] <= $signed(rl_eff);
			ph_q[ch_s1] <= $signed(rh_eff);
		end
	end

	// ---------------------------------------------------------------- multipliers
	always_comb begin
		mi_v   = v_s2 || gain_issue;
		mi_tag = '{gain: 1'b0, ch: ch_s2, stage: k_s2, first: 1'b0, last: 1'b0};
		a_l    = diffl_s2;
		a_h    = diffh_s2;
		b_l    = BW'(coef_l);
		b_h    = BW'(coef_h);
		if (gain_issue) begin
			mi_tag = '{gain: 1'b1, ch: gch, stage: '0, first: gfirst, last: glast};
			a_l    = gfirst ? DW'(xl_q[gch]) : m_q[gch];
			a_h    = gfirst ? h_q[gch] : '0;
			b_l    = gfirst ? BW'(low_gain_q) : BW'(mid_gain_q);
			b_h    = BW'(high_gain_q);
		end
	end

	tbeq_mul #(.A_W(DW), .B_W(BW)) u_mul_low (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_v    (mi_v),
		.in_tag  (mi_tag),
		.a       (a_l),
		.b       (b_l),
		.out_v   (mul_v_l),
		.out_tag (mul_tag_l),
		.prod    (prod_l)
	);

	tbeq_mul #(.A_W(DW), .B_W(BW)) u_mul_high (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_v    (mi_v),
		.in_tag  (mi_tag),
		.a       (a_h),
		.b       (b_h),
		.out_v   (mul_v_h),
		.out_tag (mul_tag_h),
		.prod    (prod_h)
	);

	// ---------------------------------------------------------------- write-back
	assign suml  = SW'(pl_q[w_ch]) + SW'(prod_l >>> COEF_FRAC_BITS);
	assign sumh  = SW'(ph_q[w_ch]) + SW'(prod_h >>> COEF_FRAC_BITS);
	assign newpl = sat_pole(suml);
	assign newph = sat_pole(sumh);

	always_ff @(posedge clk) begin
		if (accept) begin
			xl_q[0]  <= PB'(audio.left_in) <<< POLE_EXTRA_BITS;
			xh_q[0]  <= PB'(audio.left_in) <<< POLE_EXTRA_BITS;
			xl_q[1]  <= PB'(audio.right_in) <<< POLE_EXTRA_BITS;
			xh_q[1]  <= PB'(audio.right_in) <<< POLE_EXTRA_BITS;
			smp_q[0] <= audio.left_in;
			smp_q[1] <= audio.right_in;
		end else if (w_v) begin
			xl_q[w_ch] <= newpl;
			xh_q[w_ch] <= newph;
		end
	end

	// ---------------------------------------------------------------- bands
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NCH; c++)
				for (int j = 0; j < HD; j++)
					hist_q[c][j] <= '0;
		end else if (state_q == tbeq_pkg::ST_PREP) begin
			for (int c = 0; c < NCH; c++) begin
				for (int j = HD - 1; j > 0; j--)
					hist_q[c][j] <= hist_q[c][j-1];
				hist_q[c][0] <= smp_q[c];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == tbeq_pkg::ST_PREP) begin
			for (int c = 0; c < NCH; c++) begin
				h_q[c] <= DW'(PB'(hist_q[c][HD-1]) <<< POLE_EXTRA_BITS) - DW'(xh_q[c]);
				m_q[c] <= DW'(xh_q[c]) - DW'(xl_q[c]);
			end
		end
	end

	assign tl = AW'(prod_l >>> tbeq_pkg::GAIN_FRAC);
	assign th = AW'(prod_h >>> tbeq_pkg::GAIN_FRAC);

	always_ff @(posedge clk) begin
		if (g_v) begin
			if (mul_tag_l.first)
				acc_q[mul_tag_l.ch] <= tl + th;
			else
				acc_q[mul_tag_l.ch] <= acc_q[mul_tag_l.ch] + tl + th;
		end
	end

	// ---------------------------------------------------------------- output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_v_q <= 1'b0;
		else if (fin_load)
			out_v_q <= 1'b1;
		else if (equalized.ready)
			out_v_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (fin_load) begin
			left_q  <= sat_out(acc_q[0] >>> POLE_EXTRA_BITS);
			right_q <= sat_out(acc_q[1] >>> POLE_EXTRA_BITS);
		end
	end

	assign equalized.valid     = out_v_q;
	assign equalized.left_out  = left_q;
	assign equalized.right_out = right_q;

	// ---------------------------------------------------------------- checks
	a_rw_apart: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_v && w_v) |-> (raddr != waddr))
		else $error("pole RAM read and write hit the same entry");

	a_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		(mul_v_l == mul_v_h) && (!mul_v_l || (mul_tag_l == mul_tag_h)))
		else $error("multipliers out of step");

	a_done_in_pole: assert property (@(posedge clk) disable iff (!arst_n)
		pole_done |-> (state_q == tbeq_pkg::ST_POLE))
		else $error("pole chain finished outside pole phase");

	a_quiet_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tbeq_pkg::ST_IDLE) |-> (!mul_v_l && !v_s1 && !v_s2 && !rd_v))
		else $error("work in flight while idle");

endmodule

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the three-band equaliser. Stereo frames go in over
// the audio channel and every accepted transaction is run through a
// bit-exact fixed-point model of the two pole cascades, the input delay and
// the band gains. Each equalised frame that comes back is compared with the
// oldest prediction. Settings change only while the block is idle. Traffic
// runs with and without random gaps on either side, with a long output hold
// and with a full drain part way through.
// ----------------------------------------------------------------------------
module testbench;

	localparam int SAMPLE_BITS     = 24;
	localparam int COEF_FRAC_BITS  = 16;
	localparam int POLE_EXTRA_BITS = 16;
	localparam int POLE_W          = SAMPLE_BITS + POLE_EXTRA_BITS;
	localparam int CLK_PERIOD      = 8;
	localparam int RESET_CYCLES    = 6;
	localparam int LATENCY         = 32;
	localparam int TIMEOUT_CYCLES  = 1000000;
	localparam int PHASE_ITEMS     = 350;

	typedef logic signed [SAMPLE_BITS-1:0]       sample_t;
	typedef logic signed [POLE_W-1:0]            pole_t;
	typedef logic [tbeq_pkg::COEF_REG_W-1:0]     coef_t;
	typedef logic [tbeq_pkg::GAIN_W-1:0]         gain_t;

	typedef struct {
		sample_t left;
		sample_t right;
	} frame_t;

	localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
	localparam coef_t   COEF_MAX   = '1;
	localparam gain_t   GAIN_MAX   = '1;

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_we;
	logic [tbeq_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [tbeq_pkg::COEF_REG_W-1:0] cfg_wdata;

	tbeq_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) audio_if ();
	tbeq_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) eq_if ();

	three_band_equalizer #(
		.SAMPLE_BITS    (SAMPLE_BITS),
		.COEF_FRAC_BITS (COEF_FRAC_BITS),
		.POLE_EXTRA_BITS(POLE_EXTRA_BITS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.audio    (audio_if),
		.equalized(eq_if)
	);

	// model copy of the registers and filter state
	coef_t   low_coef;
	coef_t   high_coef;
	gain_t   low_gain;
	gain_t   mid_gain;
	gain_t   high_gain;
	pole_t   low_poles [tbeq_pkg::N_CH][tbeq_pkg::N_STAGES];
	pole_t   high_poles[tbeq_pkg::N_CH][tbeq_pkg::N_STAGES];
	sample_t history   [tbeq_pkg::N_CH][tbeq_pkg::HIST_DEPTH];

	frame_t  pending_frames[$];
	int      mismatch_count;
	int      tx_idle_pct;
	int      rx_stall_pct;
	int      rx_hold_request;

	function automatic longint floor_mul(longint a, longint b, int shift);
		return (a * b) >>> shift;
	endfunction

	function automatic longint clamp(longint v, int bits);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (bits - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) begin
			return hi;
		end
		if (v < lo) begin
			return lo;
		end
		return v;
	endfunction

	function automatic longint run_cascade(bit high_band, int ch, longint x);
		longint coef;
		longint p;
		coef = high_band ? high_coef : low_coef;
		for (int k = 0; k < tbeq_pkg::N_STAGES; k++) begin
			p = high_band ? high_poles[ch][k] : low_poles[ch][k];
			p = clamp(p + floor_mul(x - p, coef, COEF_FRAC_BITS), POLE_W);
			if (high_band) begin
				high_poles[ch][k] = pole_t'(p);
			end else begin
				low_poles[ch][k] = pole_t'(p);
			end
			x = p;
		end
		return x;
	endfunction

	function automatic sample_t equalize_channel(int ch, sample_t s);
		longint x;
		longint lo;
		longint hp;
		longint dly;
		longint hi;
		longint mid;
		longint acc;
		x   = longint'(s) <<< POLE_EXTRA_BITS;
		lo  = run_cascade(1'b0, ch, x);
		hp  = run_cascade(1'b1, ch, x);
		dly = longint'(history[ch][tbeq_pkg::HIST_DEPTH-1]) <<< POLE_EXTRA_BITS;
		hi  = dly - hp;
		mid = dly - (hi + lo);
		acc = floor_mul(lo, low_gain, tbeq_pkg::GAIN_FRAC)
			+ floor_mul(mid, mid_gain, tbeq_pkg::GAIN_FRAC)
			+ floor_mul(hi, high_gain, tbeq_pkg::GAIN_FRAC);
		for (int a = tbeq_pkg::HIST_DEPTH - 1; a > 0; a--) begin
			history[ch][a] = history[ch][a-1];
		end
		history[ch][0] = s;
		return sample_t'(clamp(acc >>> POLE_EXTRA_BITS, SAMPLE_BITS));
	endfunction

	function automatic frame_t equalize_frame(sample_t l, sample_t r);
		frame_t f;
		f.left  = equalize_channel(0, l);
		f.right = equalize_channel(1, r);
		return f;
	endfunction

	// full scale a quarter of the time, otherwise sign-extended from a random width of 1 to SAMPLE_BITS bits
	function automatic sample_t random_sample();
		int unsigned w;
		logic [31:0] r;
		w = $urandom_range(SAMPLE_BITS, 1);
		r = $urandom;
		if ($urandom_range(3) == 0) begin
			return sample_t'(r);
		end
		return sample_t'($signed(r << (32 - w)) >>> (32 - w));
	endfunction

	task automatic write_reg(input logic [tbeq_pkg::CFG_IDX_W-1:0] idx, input coef_t data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		case (idx)
			tbeq_pkg::CFG_LOW_COEF:  low_coef  = data;
			tbeq_pkg::CFG_HIGH_COEF: high_coef = data;
			tbeq_pkg::CFG_LOW_GAIN:  low_gain  = data[tbeq_pkg::GAIN_W-1:0];
			tbeq_pkg::CFG_MID_GAIN:  mid_gain  = data[tbeq_pkg::GAIN_W-1:0];
			tbeq_pkg::CFG_HIGH_GAIN: high_gain = data[tbeq_pkg::GAIN_W-1:0];
			default: ;
		endcase
	endtask

	task automatic apply_settings(input coef_t lc, input coef_t hc, input gain_t lg,
			input gain_t mg, input gain_t hg);
		write_reg(tbeq_pkg::CFG_LOW_COEF, lc);
		write_reg(tbeq_pkg::CFG_HIGH_COEF, hc);
		write_reg(tbeq_pkg::CFG_LOW_GAIN, coef_t'(lg));
		write_reg(tbeq_pkg::CFG_MID_GAIN, coef_t'(mg));
		write_reg(tbeq_pkg::CFG_HIGH_GAIN, coef_t'(hg));
		cfg_we <= 1'b0;
	endtask

	task automatic apply_random_settings();
		coef_t lc;
		coef_t hc;
		lc = $urandom_range(1) ? coef_t'($urandom_range(COEF_MAX)) : coef_t'($urandom_range(65535));
		hc = $urandom_range(1) ? coef_t'($urandom_range(COEF_MAX)) : coef_t'($urandom_range(65535));
		apply_settings(lc, hc, gain_t'($urandom), gain_t'($urandom), gain_t'($urandom));
	endtask

	// valid stays high from one transaction to the next unless a gap is drawn
	task automatic send_frame(input sample_t l, input sample_t r);
		if ($urandom_range(99) < tx_idle_pct) begin
			audio_if.valid <= 1'b0;
			do begin
				@(posedge clk);
			end while ($urandom_range(99) < tx_idle_pct);
		end
		audio_if.valid    <= 1'b1;
		audio_if.left_in  <= l;
		audio_if.right_in <= r;
		@(posedge clk);
		while (!audio_if.ready) begin
			@(posedge clk);
		end
		pending_frames.push_back(equalize_frame(l, r));
	endtask

	task automatic wait_drained();
		audio_if.valid <= 1'b0;
		while (pending_frames.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic compare_frame(input sample_t l, input sample_t r);
		frame_t want;
		if (pending_frames.size() == 0) begin
			mismatch_count++;
			$display("%0t: unexpected result transaction, expected none, got %0d %0d",
				$time, l, r);
			return;
		end
		want = pending_frames.pop_front();
		if (l !== want.left) begin
			mismatch_count++;
			$display("%0t: left_out mismatch, expected %0d, got %0d", $time, want.left, l);
		end
		if (r !== want.right) begin
			mismatch_count++;
			$display("%0t: right_out mismatch, expected %0d, got %0d", $time, want.right, r);
		end
	endtask

	task automatic test_reset_defaults();
		send_frame(SAMPLE_MAX, SAMPLE_MAX);
		send_frame(SAMPLE_MIN, SAMPLE_MIN);
		send_frame('0, '0);
		send_frame(-1, 1);
		send_frame(SAMPLE_MAX, SAMPLE_MIN);
		send_frame(SAMPLE_MIN, SAMPLE_MAX);
		send_frame('0, '0);
		send_frame('0, '0);
		wait_drained();
	endtask

	// coefficients near two make the poles ring into saturation
	task automatic test_register_extremes();
		apply_settings(COEF_MAX, COEF_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX);
		for (int i = 0; i < 6; i++) begin
			send_frame(i[0] ? SAMPLE_MIN : SAMPLE_MAX, i[0] ? SAMPLE_MAX : SAMPLE_MIN);
		end
		wait_drained();
		apply_settings('0, COEF_MAX, GAIN_MAX, '0, GAIN_MAX);
		send_frame(SAMPLE_MAX, SAMPLE_MIN);
		send_frame(SAMPLE_MIN, SAMPLE_MAX);
		send_frame(random_sample(), random_sample());
		wait_drained();
		apply_settings(COEF_MAX, '0, '0, GAIN_MAX, '0);
		send_frame(SAMPLE_MIN, SAMPLE_MIN);
		send_frame(SAMPLE_MAX, SAMPLE_MAX);
		send_frame(random_sample(), random_sample());
		wait_drained();
	endtask

	task automatic test_unused_index();
		apply_settings(coef_t'(tbeq_pkg::LOW_COEF_RST), coef_t'(tbeq_pkg::HIGH_COEF_RST),
			tbeq_pkg::GAIN_RST, tbeq_pkg::GAIN_RST, tbeq_pkg::GAIN_RST);
		@(posedge clk);
		for (int i = int'(tbeq_pkg::CFG_HIGH_GAIN) + 1; i < 2 ** tbeq_pkg::CFG_IDX_W; i++) begin
			write_reg(i[tbeq_pkg::CFG_IDX_W-1:0], i[0] ? COEF_MAX : '0);
		end
		cfg_we <= 1'b0;
		send_frame(SAMPLE_MAX, SAMPLE_MIN);
		send_frame(random_sample(), random_sample());
		send_frame(random_sample(), random_sample());
		wait_drained();
	endtask

	task automatic test_idle_phase(input int tx_pct, input int rx_pct);
		apply_random_settings();
		tx_idle_pct  = tx_pct;
		rx_stall_pct = rx_pct;
		repeat (PHASE_ITEMS) begin
			send_frame(random_sample(), random_sample());
		end
		wait_drained();
	endtask

	// output held off long enough for the block to fill and stall its input
	task automatic test_output_backpressure();
		apply_random_settings();
		tx_idle_pct     = 0;
		rx_stall_pct    = 0;
		rx_hold_request = 400;
		repeat (30) begin
			send_frame(random_sample(), random_sample());
		end
		wait_drained();
	endtask

	task automatic test_sender_pause();
		apply_random_settings();
		tx_idle_pct  = 28;
		rx_stall_pct = 28;
		repeat (60) begin
			send_frame(random_sample(), random_sample());
		end
		wait_drained();
		repeat (60) begin
			send_frame(random_sample(), random_sample());
		end
		wait_drained();
	endtask

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	initial begin
		int hold_left;
		hold_left = 0;
		eq_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (eq_if.valid && eq_if.ready) begin
				compare_frame(eq_if.left_out, eq_if.right_out);
			end
			if (rx_hold_request > 0) begin
				hold_left       = rx_hold_request;
				rx_hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				eq_if.ready <= 1'b0;
			end else begin
				eq_if.ready <= ($urandom_range(99) >= rx_stall_pct);
			end
		end
	end

	initial begin
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("three_band_equalizer verification failed");
		$finish;
	end

	initial begin
		arst_n            <= 1'b0;
		cfg_we            <= 1'b0;
		cfg_index         <= '0;
		cfg_wdata         <= '0;
		audio_if.valid    <= 1'b0;
		audio_if.left_in  <= '0;
		audio_if.right_in <= '0;
		mismatch_count  = 0;
		tx_idle_pct     = 0;
		rx_stall_pct    = 0;
		rx_hold_request = 0;
		low_coef        = tbeq_pkg::LOW_COEF_RST;
		high_coef       = tbeq_pkg::HIGH_COEF_RST;
		low_gain        = tbeq_pkg::GAIN_RST;
		mid_gain        = tbeq_pkg::GAIN_RST;
		high_gain       = tbeq_pkg::GAIN_RST;
		foreach (low_poles[c, k]) begin
			low_poles[c][k]  = '0;
			high_poles[c][k] = '0;
		end
		foreach (history[c, a]) begin
			history[c][a] = '0;
		end
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_register_extremes();
		test_unused_index();
		test_idle_phase(0, 0);
		test_idle_phase(74, 0);
		test_idle_phase(0, 74);
		test_idle_phase(28, 28);
		test_output_backpressure();
		test_sender_pause();

		wait_drained();
		repeat (2 * LATENCY) @(posedge clk);
		if (mismatch_count == 0 && pending_frames.size() == 0) begin
			$display("three_band_equalizer verification clean");
		end else begin
			$display("three_band_equalizer verification failed");
		end
		$finish;
	end

endmodule
